// ----- hw/rtl/rit_pkg.sv -----
package rit_pkg;

  // width of a process id; results above the limit are not found
  localparam int unsigned ID_BITS = 32;
  localparam logic [32:0] ID_LIMIT = (ID_BITS >= 32) ? 33'h0_FFFF_FFFF :
                                     33'((64'd1 << ID_BITS) - 64'd1);

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CNT_W = 6;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TO_ID   = 2'd1,
    OP_TO_RANK = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_MODE   = 3'd0,
    CFG_GROUP_SIZE   = 3'd1,
    CFG_BASE_OFFSET  = 3'd2,
    CFG_BLOCK_STRIDE = 3'd3,
    CFG_BLOCK_LENGTH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [32:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

// ----- hw/rtl/rit_cfg_if.sv -----
interface rit_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rit_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/rit_in_if.sv -----
interface rit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] rank_in;
  logic [31:0] id_in;

  modport source (output valid, output operation, output rank_in, output id_in, input ready);
  modport sink   (input valid, input operation, input rank_in, input id_in, output ready);
endinterface

// ----- hw/rtl/rit_out_if.sv -----
interface rit_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] id_out;
  logic [7:0]  rank_out;
  logic        found;

  modport source (output valid, output id_out, output rank_out, output found, input ready);
  modport sink   (input valid, input id_out, input rank_out, input found, output ready);
endinterface

// ----- hw/rtl/rit_div.sv -----
module rit_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rit_pkg::div_req_t req_i,
  output rit_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [rit_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [31:0]                   rem_q;
  logic [32:0]                   quo_q;
  logic [31:0]                   dvs_q;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic [31:0] rem_next;
  logic [32:0] quo_next;

  // one shift-subtract step
  always_comb begin
    rem_sh   = {rem_q, quo_q[32]};
    rem_sub  = rem_sh - {1'b0, dvs_q};
    ge       = (rem_sh >= {1'b0, dvs_q});
    rem_next = ge ? rem_sub[31:0] : rem_sh[31:0];
    quo_next = {quo_q[31:0], ge};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == rit_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= rit_pkg::DIV_CNT_W'(rit_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - rit_pkg::DIV_CNT_W'(1);
        if (cnt_q == rit_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- hw/rtl/rank_id_translator_top.sv -----
// channel  modport        handshake       payload
// cfg_i    sink           valid/ready     index, data (always ready)
// req_i    sink           valid/ready     operation, rank_in, id_in
// rsp_o    source         valid/ready     id_out, rank_out, found
//
// one transaction at a time: accept, decode, then the work, then the output register
// strided translation: runs through the 33-step shared divider
// table search: one entry per cycle through the single table read port
// a waiting result does not block the next accept; a new result waits for the output register
// reset clears the configuration and control registers, the id table holds garbage until written
module rank_id_translator_top #(
  parameter int unsigned MAX_RANKS = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rit_cfg_if.sink   cfg_i,
  rit_in_if.sink    req_i,
  rit_out_if.source rsp_o
);

  localparam int unsigned AW = $clog2(MAX_RANKS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_TCHK   = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_CHK    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  // configuration
  logic               table_mode_q;
  logic [8:0]         group_size_q;
  logic [31:0]        base_offset_q;
  logic signed [31:0] block_stride_q;
  logic [8:0]         block_length_q;

  state_e state_q, state_d;

  logic [1:0]  op_q;
  logic [15:0] rank_q;
  logic [31:0] id_q;

  logic [33:0] q_q, q_d;
  logic [31:0] m_q, m_d;
  logic        fail_q, fail_d;
  logic signed [42:0] prod_q;

  logic [31:0] res_id_q, res_id_d;
  logic [7:0]  res_rank_q, res_rank_d;
  logic        res_found_q, res_found_d;

  logic        rsp_valid_q;
  logic [31:0] rsp_id_q;
  logic [7:0]  rsp_rank_q;
  logic        rsp_found_q;

  logic [31:0] mem_q [MAX_RANKS];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] raddr;
  logic [8:0]  scan_cnt_q, scan_cnt_d;
  logic [8:0]  rd_idx_q;
  logic        rd_vld_q;

  rit_pkg::div_req_t div_req;
  rit_pkg::div_rsp_t div_rsp;

  logic [8:0]  eff_size;
  logic        rank_ok;
  logic        wr_ok;
  logic        d_neg;
  logic [31:0] d_mag;
  logic        s_neg;
  logic [31:0] s_mag;
  logic        bad_strided;
  logic        scan_issue;

  logic signed [32:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [44:0] base_s, prod_s, m_s, v_sum;
  logic [42:0]        r_sum;
  logic               in_acc;
  logic               rsp_load;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_mode_q   <= 1'b0;
      group_size_q   <= 9'd1;
      base_offset_q  <= '0;
      block_stride_q <= 32'sd1;
      block_length_q <= 9'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rit_pkg::CFG_TABLE_MODE:   table_mode_q   <= cfg_i.data[0];
        rit_pkg::CFG_GROUP_SIZE:   group_size_q   <= cfg_i.data[8:0];
        rit_pkg::CFG_BASE_OFFSET:  base_offset_q  <= cfg_i.data;
        rit_pkg::CFG_BLOCK_STRIDE: block_stride_q <= cfg_i.data;
        rit_pkg::CFG_BLOCK_LENGTH: block_length_q <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  // derived operands
  always_comb begin
    eff_size    = (17'(group_size_q) > 17'(MAX_RANKS)) ? 9'(MAX_RANKS) : group_size_q;
    rank_ok     = (rank_q < 16'(eff_size));
    wr_ok       = (17'(rank_q) < 17'(MAX_RANKS));
    d_neg       = (id_q < base_offset_q);
    d_mag       = d_neg ? (base_offset_q - id_q) : (id_q - base_offset_q);
    s_neg       = block_stride_q[31];
    s_mag       = s_neg ? (~block_stride_q + 32'd1) : block_stride_q;
    bad_strided = (block_length_q == 9'd0) || (block_stride_q == 32'sd0);
    scan_issue  = (state_q == S_SCAN) && (scan_cnt_q < eff_size);
  end

  // shared divider
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = (op_q == rit_pkg::OP_TO_ID) ? 33'(rank_q) : 33'(d_mag);
    div_req.divisor  = (op_q == rit_pkg::OP_TO_ID) ? 32'(block_length_q) : s_mag;
    if ((state_q == S_DECODE) && !table_mode_q && !bad_strided) begin
      div_req.start = ((op_q == rit_pkg::OP_TO_ID) && rank_ok) ||
                      (op_q == rit_pkg::OP_TO_RANK);
    end
  end

  rit_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // final sums after the multiply, and the multiply operands
  always_comb begin
    base_s = {13'b0, base_offset_q};
    prod_s = {{2{prod_q[42]}}, prod_q};
    m_s    = {36'b0, m_q[8:0]};
    v_sum  = base_s + prod_s + m_s;
    r_sum  = prod_q + 43'(m_q[8:0]);
    mul_a  = (op_q == rit_pkg::OP_TO_ID) ? {block_stride_q[31], block_stride_q} :
                                           {24'b0, block_length_q};
    mul_b  = {1'b0, q_q[8:0]};
  end

  // id table ports
  always_comb begin
    mem_we = (state_q == S_DECODE) && (op_q == rit_pkg::OP_WRITE) && wr_ok;
    mem_re = scan_issue ||
             ((state_q == S_DECODE) && (op_q == rit_pkg::OP_TO_ID) && rank_ok && table_mode_q);
    raddr  = (state_q == S_SCAN) ? AW'(scan_cnt_q) : rank_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[rank_q[AW-1:0]] <= id_q;
    end
    if (mem_re) begin
      rdata_q  <= mem_q[raddr];
      rd_idx_q <= scan_cnt_q;
    end
  end

  // sequencer
  assign in_acc   = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    q_d         = q_q;
    m_d         = m_q;
    fail_d      = fail_q;
    scan_cnt_d  = scan_cnt_q;
    res_id_d    = res_id_q;
    res_rank_d  = res_rank_q;
    res_found_d = res_found_q;
    if (scan_issue) begin
      scan_cnt_d = scan_cnt_q + 9'd1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_id_d    = '0;
        res_rank_d  = '0;
        res_found_d = 1'b0;
        scan_cnt_d  = '0;
        state_d     = S_DONE;
        unique case (op_q)
          rit_pkg::OP_WRITE: res_found_d = wr_ok;
          rit_pkg::OP_TO_ID: begin
            if (rank_ok && table_mode_q) begin
              state_d = S_TCHK;
            end else if (rank_ok && !bad_strided) begin
              state_d = S_DIV;
            end
          end
          rit_pkg::OP_TO_RANK: begin
            if (table_mode_q) begin
              state_d = S_SCAN;
            end else if (!bad_strided) begin
              state_d = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_TCHK: begin
        if (33'(rdata_q) <= rit_pkg::ID_LIMIT) begin
          res_id_d    = rdata_q;
          res_found_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (rd_vld_q && (rdata_q == id_q)) begin
          res_rank_d  = rd_idx_q[7:0];
          res_found_d = 1'b1;
          state_d     = S_DONE;
        end else if (!rd_vld_q && !scan_issue) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fail_d  = 1'b0;
          q_d     = 34'(div_rsp.quotient);
          m_d     = div_rsp.remainder;
          state_d = S_CHK;
          if (op_q == rit_pkg::OP_TO_RANK) begin
            // negative remainder: fix up quotient and remainder; fails for a positive stride
            if (d_neg && (div_rsp.remainder != 32'd0)) begin
              fail_d = !s_neg;
              q_d    = 34'(div_rsp.quotient) + 34'd1;
              m_d    = s_mag - div_rsp.remainder;
            end else begin
              fail_d = (d_neg ^ s_neg) && (div_rsp.quotient != 33'd0);
            end
          end
        end
      end
      S_CHK: begin
        if (fail_q || (q_q >= 34'(eff_size)) || (m_q >= 32'(block_length_q))) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_FIN;
      S_FIN: begin
        if (op_q == rit_pkg::OP_TO_ID) begin
          if (!v_sum[44] && (v_sum[43:0] <= 44'(rit_pkg::ID_LIMIT))) begin
            res_id_d    = v_sum[31:0];
            res_found_d = 1'b1;
          end
        end else if (r_sum < 43'(eff_size)) begin
          res_rank_d  = r_sum[7:0];
          res_found_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= req_i.operation;
      rank_q <= req_i.rank_in;
      id_q   <= req_i.id_in;
    end
    q_q         <= q_d;
    m_q         <= m_d;
    fail_q      <= fail_d;
    scan_cnt_q  <= scan_cnt_d;
    res_id_q    <= res_id_d;
    res_rank_q  <= res_rank_d;
    res_found_q <= res_found_d;
    if (state_q == S_MUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (rsp_load) begin
      rsp_id_q    <= res_id_q;
      rsp_rank_q  <= res_rank_q;
      rsp_found_q <= res_found_q;
    end
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.id_out   = rsp_id_q;
  assign rsp_o.rank_out = rsp_rank_q;
  assign rsp_o.found    = rsp_found_q;

  // no new transaction while the divider is running
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

  // divider results only land in the divide state
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");

  // a miss carries zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |-> ((rsp_o.id_out == '0) && (rsp_o.rank_out == '0)))
    else $error("not-found result with nonzero fields");

endmodule
